// ===== rtl/core/rpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared widths, constants and rounding helpers for the relative pose
// predictor.
// ----------------------------------------------------------------------------
package rpp_pkg;

    localparam int ROT_W    = 16;
    localparam int POS_W    = 32;
    localparam int FRAC_W   = 14;
    localparam int DIFF_W   = POS_W + 1;
    localparam int RPROD_W  = 2 * ROT_W;
    localparam int RSUM_W   = RPROD_W + 2;
    localparam int RQ_W     = RSUM_W + 1 - FRAC_W;
    localparam int TPROD_W  = ROT_W + DIFF_W;
    localparam int TSUM_W   = TPROD_W + 2;
    localparam int TQ_W     = TSUM_W + 1 - FRAC_W;
    localparam int ROT_N    = 9;
    localparam int POS_N    = 3;

    localparam logic [ROT_W-1:0] ROT_ONE    = 16'h4000;
    localparam logic [ROT_W-1:0] ROT_MAX    = 16'h7FFF;
    localparam logic [ROT_W-1:0] ROT_MIN    = 16'h8000;
    localparam logic [POS_W-1:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN    = 32'h8000_0000;
    localparam int               ROUND_BIAS = 1 << (FRAC_W - 1);

    typedef logic signed [ROT_W-1:0]   rot_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [RPROD_W-1:0] rprod_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;

    // Round half up to Q2.14, saturate to 16 bits.
    function automatic rot_t round_sat_rot(input logic signed [RSUM_W-1:0] x);
        logic signed [RSUM_W:0] b;
        logic [RQ_W-1:0]        q;
        b = $signed({x[RSUM_W-1], x}) + $signed((RSUM_W+1)'(ROUND_BIAS));
        q = b[RSUM_W:FRAC_W];
        if ((&q[RQ_W-1:ROT_W-1]) || !(|q[RQ_W-1:ROT_W-1])) begin
            return rot_t'(q[ROT_W-1:0]);
        end
        return q[RQ_W-1] ? rot_t'(ROT_MIN) : rot_t'(ROT_MAX);
    endfunction

    // Round half up to Q16.16, saturate to 32 bits.
    function automatic pos_t round_sat_pos(input logic signed [TSUM_W-1:0] x);
        logic signed [TSUM_W:0] b;
        logic [TQ_W-1:0]        q;
        b = $signed({x[TSUM_W-1], x}) + $signed((TSUM_W+1)'(ROUND_BIAS));
        q = b[TSUM_W:FRAC_W];
        if ((&q[TQ_W-1:POS_W-1]) || !(|q[TQ_W-1:POS_W-1])) begin
            return pos_t'(q[POS_W-1:0]);
        end
        return q[TQ_W-1] ? pos_t'(POS_MIN) : pos_t'(POS_MAX);
    endfunction

endpackage

// ===== rtl/core/relative_pose_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// relative_pose_predictor_unit
// Relative rigid transform between consecutive poses: R_prev^T * R_new and
// R_prev^T * (t_new - t_prev), identity until two poses have been seen.
// ----------------------------------------------------------------------------
// Accepts one pose per cycle while in_ready is high and delivers one
// transaction per pose, in order. After input capture each pose passes a
// register chain: rotation products and translation differences, rotation
// sums with translation products, and the output register. Each
// stage holds its item under back-pressure while earlier empty stages still
// fill, so in_ready drops only when every stage is occupied and stalled.
module relative_pose_predictor_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_00,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_01,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_02,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_10,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_11,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_12,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_20,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_21,
    input  logic signed [rpp_pkg::ROT_W-1:0] rot_22,
    input  logic signed [rpp_pkg::POS_W-1:0] pos_x,
    input  logic signed [rpp_pkg::POS_W-1:0] pos_y,
    input  logic signed [rpp_pkg::POS_W-1:0] pos_z,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_00,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_01,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_02,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_10,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_11,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_12,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_20,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_21,
    output logic signed [rpp_pkg::ROT_W-1:0] pred_rot_22,
    output logic signed [rpp_pkg::POS_W-1:0] pred_pos_x,
    output logic signed [rpp_pkg::POS_W-1:0] pred_pos_y,
    output logic signed [rpp_pkg::POS_W-1:0] pred_pos_z
);

    localparam int RN = rpp_pkg::ROT_N;
    localparam int PN = rpp_pkg::POS_N;

    rpp_pkg::rot_t   rot_in [RN];
    rpp_pkg::pos_t   pos_in [PN];

    rpp_pkg::rot_t   prev_rot_reg [RN];
    rpp_pkg::pos_t   prev_pos_reg [PN];
    logic [1:0]      seen_reg;

    // stage 0: captured pose and previous pose
    logic            v0_reg;
    logic            id0_reg;
    rpp_pkg::rot_t   new_rot0_reg [RN];
    rpp_pkg::pos_t   new_pos0_reg [PN];
    rpp_pkg::rot_t   old_rot0_reg [RN];
    rpp_pkg::pos_t   old_pos0_reg [PN];

    // stage 1: rotation products, translation differences
    logic            v1_reg;
    logic            id1_reg;
    rpp_pkg::rprod_t rprod1_reg [RN*3];
    rpp_pkg::diff_t  diff1_reg [PN];
    rpp_pkg::rot_t   old_rot1_reg [RN];

    // stage 2: rounded rotation, translation products
    logic            v2_reg;
    logic            id2_reg;
    rpp_pkg::rot_t   rot2_reg [RN];
    rpp_pkg::tprod_t tprod2_reg [PN*3];

    // stage 3: output
    logic            v3_reg;
    rpp_pkg::rot_t   rot3_reg [RN];
    rpp_pkg::pos_t   pos3_reg [PN];

    logic            ready0;
    logic            ready1;
    logic            ready2;
    logic            ready3;
    logic            accept;

    assign rot_in[0] = rot_00;
    assign rot_in[1] = rot_01;
    assign rot_in[2] = rot_02;
    assign rot_in[3] = rot_10;
    assign rot_in[4] = rot_11;
    assign rot_in[5] = rot_12;
    assign rot_in[6] = rot_20;
    assign rot_in[7] = rot_21;
    assign rot_in[8] = rot_22;
    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign ready0   = !v0_reg || ready1;
    assign in_ready = ready0;
    assign accept   = in_valid && ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            seen_reg <= 2'd0;
            for (int n = 0; n < RN; n++)
            begin
                prev_rot_reg[n] <= '0;
            end
            for (int n = 0; n < PN; n++)
            begin
                prev_pos_reg[n] <= '0;
            end
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= in_valid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (accept)
            begin
                if (seen_reg != 2'd2)
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
                for (int n = 0; n < RN; n++)
                begin
                    prev_rot_reg[n] <= rot_in[n];
                end
                for (int n = 0; n < PN; n++)
                begin
                    prev_pos_reg[n] <= pos_in[n];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id0_reg <= (seen_reg == 2'd0);
            for (int n = 0; n < RN; n++)
            begin
                new_rot0_reg[n] <= rot_in[n];
                old_rot0_reg[n] <= prev_rot_reg[n];
            end
            for (int n = 0; n < PN; n++)
            begin
                new_pos0_reg[n] <= pos_in[n];
                old_pos0_reg[n] <= prev_pos_reg[n];
            end
        end

        // product index: (i*3 + j)*3 + k, term prev[k][i] * new[k][j]
        if (ready1 && v0_reg)
        begin
            id1_reg <= id0_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rprod1_reg[(i*3+j)*3+k] <=
                              rpp_pkg::rprod_t'(old_rot0_reg[k*3+i])
                            * rpp_pkg::rprod_t'(new_rot0_reg[k*3+j]);
                    end
                end
            end
            for (int n = 0; n < PN; n++)
            begin
                diff1_reg[n] <= rpp_pkg::diff_t'(new_pos0_reg[n])
                              - rpp_pkg::diff_t'(old_pos0_reg[n]);
            end
            for (int n = 0; n < RN; n++)
            begin
                old_rot1_reg[n] <= old_rot0_reg[n];
            end
        end

        if (ready2 && v1_reg)
        begin
            id2_reg <= id1_reg;
            for (int n = 0; n < RN; n++)
            begin
                rot2_reg[n] <= rpp_pkg::round_sat_rot(
                      (rpp_pkg::RSUM_W)'(rprod1_reg[n*3])
                    + (rpp_pkg::RSUM_W)'(rprod1_reg[n*3+1])
                    + (rpp_pkg::RSUM_W)'(rprod1_reg[n*3+2]));
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    tprod2_reg[i*3+k] <= rpp_pkg::tprod_t'(old_rot1_reg[k*3+i])
                                       * rpp_pkg::tprod_t'(diff1_reg[k]);
                end
            end
        end

        if (ready3 && v2_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (id2_reg)
                    begin
                        rot3_reg[i*3+j] <= (i == j) ? rpp_pkg::rot_t'(rpp_pkg::ROT_ONE) : '0;
                    end
                    else
                    begin
                        rot3_reg[i*3+j] <= rot2_reg[i*3+j];
                    end
                end
            end
            for (int n = 0; n < PN; n++)
            begin
                if (id2_reg)
                begin
                    pos3_reg[n] <= '0;
                end
                else
                begin
                    pos3_reg[n] <= rpp_pkg::round_sat_pos(
                          (rpp_pkg::TSUM_W)'(tprod2_reg[n*3])
                        + (rpp_pkg::TSUM_W)'(tprod2_reg[n*3+1])
                        + (rpp_pkg::TSUM_W)'(tprod2_reg[n*3+2]));
                end
            end
        end
    end

    assign out_valid   = v3_reg;
    assign pred_rot_00 = rot3_reg[0];
    assign pred_rot_01 = rot3_reg[1];
    assign pred_rot_02 = rot3_reg[2];
    assign pred_rot_10 = rot3_reg[3];
    assign pred_rot_11 = rot3_reg[4];
    assign pred_rot_12 = rot3_reg[5];
    assign pred_rot_20 = rot3_reg[6];
    assign pred_rot_21 = rot3_reg[7];
    assign pred_rot_22 = rot3_reg[8];
    assign pred_pos_x  = pos3_reg[0];
    assign pred_pos_y  = pos3_reg[1];
    assign pred_pos_z  = pos3_reg[2];

endmodule

// ===== bench/relative_pose_predictor_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_pose_predictor_unit_test
// Drives poses into relative_pose_predictor_unit and checks each relative
// transform against a predictor of the block. A directed table of poses comes
// first: the identity while fewer than two poses are seen, field extremes,
// rotation and translation saturation, and rounding ties. Random poses follow,
// half of them near-rotations, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module relative_pose_predictor_unit_test;

    localparam int RANDOM_ITEMS = 433;
    localparam int DIRECTED_N   = 17;
    localparam int TOTAL_ITEMS  = DIRECTED_N + RANDOM_ITEMS;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 60;
    localparam int HOLD_ITEM    = 100;
    localparam int PAUSE_ITEM   = 250;
    localparam int UNIT         = int'(rpp_pkg::ROT_ONE);
    localparam int Q16          = 65536;
    localparam int RMAX         = int'(rpp_pkg::ROT_MAX);
    localparam int RMIN         = int'(rpp_pkg::ROT_MIN);
    localparam int PMAX         = int'(rpp_pkg::POS_MAX);
    localparam int PMIN         = int'(rpp_pkg::POS_MIN);

    typedef struct packed {
        logic [rpp_pkg::ROT_N-1:0][rpp_pkg::ROT_W-1:0] rot;
        logic [rpp_pkg::POS_N-1:0][rpp_pkg::POS_W-1:0] pos;
    } pose_t;

    typedef struct packed {
        pose_t stim;
        logic  has_want;
        pose_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic out_valid;
    logic out_ready;
    logic signed [rpp_pkg::ROT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [rpp_pkg::ROT_W-1:0] rot_20, rot_21, rot_22;
    logic signed [rpp_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [rpp_pkg::ROT_W-1:0] pred_rot_00, pred_rot_01, pred_rot_02;
    logic signed [rpp_pkg::ROT_W-1:0] pred_rot_10, pred_rot_11, pred_rot_12;
    logic signed [rpp_pkg::ROT_W-1:0] pred_rot_20, pred_rot_21, pred_rot_22;
    logic signed [rpp_pkg::POS_W-1:0] pred_pos_x, pred_pos_y, pred_pos_z;

    pose_t         expected_log[TOTAL_ITEMS];
    int            sent_count;
    int            taken_count;
    pose_t         last_pose;
    logic [1:0]    poses_seen;
    directed_row_t directed_rows[DIRECTED_N];
    int            error_count;
    int            result_count;
    int            idle_cycles;
    int            tx_no_gap_left;
    logic          tx_steady;
    logic          rx_steady;
    logic          long_hold;

    relative_pose_predictor_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rot_00      (rot_00),
        .rot_01      (rot_01),
        .rot_02      (rot_02),
        .rot_10      (rot_10),
        .rot_11      (rot_11),
        .rot_12      (rot_12),
        .rot_20      (rot_20),
        .rot_21      (rot_21),
        .rot_22      (rot_22),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pred_rot_00 (pred_rot_00),
        .pred_rot_01 (pred_rot_01),
        .pred_rot_02 (pred_rot_02),
        .pred_rot_10 (pred_rot_10),
        .pred_rot_11 (pred_rot_11),
        .pred_rot_12 (pred_rot_12),
        .pred_rot_20 (pred_rot_20),
        .pred_rot_21 (pred_rot_21),
        .pred_rot_22 (pred_rot_22),
        .pred_pos_x  (pred_pos_x),
        .pred_pos_y  (pred_pos_y),
        .pred_pos_z  (pred_pos_z)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic pose_t pose_from(input int r00, input int r01, input int r02,
                                        input int r10, input int r11, input int r12,
                                        input int r20, input int r21, input int r22,
                                        input int x, input int y, input int z);
        pose_t p;
        p.rot[0] = r00[rpp_pkg::ROT_W-1:0];
        p.rot[1] = r01[rpp_pkg::ROT_W-1:0];
        p.rot[2] = r02[rpp_pkg::ROT_W-1:0];
        p.rot[3] = r10[rpp_pkg::ROT_W-1:0];
        p.rot[4] = r11[rpp_pkg::ROT_W-1:0];
        p.rot[5] = r12[rpp_pkg::ROT_W-1:0];
        p.rot[6] = r20[rpp_pkg::ROT_W-1:0];
        p.rot[7] = r21[rpp_pkg::ROT_W-1:0];
        p.rot[8] = r22[rpp_pkg::ROT_W-1:0];
        p.pos[0] = x;
        p.pos[1] = y;
        p.pos[2] = z;
        return p;
    endfunction

    function automatic pose_t identity_pose();
        return pose_from(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT, 0, 0, 0);
    endfunction

    function automatic directed_row_t make_row(input pose_t stim, input logic has_want,
                                               input pose_t want);
        directed_row_t row;
        row.stim     = stim;
        row.has_want = has_want;
        row.want     = want;
        return row;
    endfunction

    // Round half up from 14 fraction bits, then clamp.
    function automatic longint round_clamp(input longint acc, input longint lo,
                                           input longint hi);
        longint q;
        q = (acc + rpp_pkg::ROUND_BIAS) >>> rpp_pkg::FRAC_W;
        if (q < lo)
            return lo;
        if (q > hi)
            return hi;
        return q;
    endfunction

    // prev^T * cur for the rotation, prev^T * (cur - prev) for the translation.
    function automatic pose_t relative_transform(input pose_t prev, input pose_t cur);
        pose_t  res;
        longint acc;
        longint a;
        longint b;
        longint d;
        longint q;
        int     i;
        int     j;
        int     k;
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                acc = 0;
                for (k = 0; k < 3; k++)
                begin
                    a = $signed(prev.rot[k*3+i]);
                    b = $signed(cur.rot[k*3+j]);
                    acc += a * b;
                end
                q = round_clamp(acc, -32768, 32767);
                res.rot[i*3+j] = q[rpp_pkg::ROT_W-1:0];
            end
        end
        for (i = 0; i < 3; i++)
        begin
            acc = 0;
            for (k = 0; k < 3; k++)
            begin
                a = $signed(prev.rot[k*3+i]);
                b = $signed(cur.pos[k]);
                d = $signed(prev.pos[k]);
                acc += a * (b - d);
            end
            q = round_clamp(acc, -64'sd2147483648, 64'sd2147483647);
            res.pos[i] = q[rpp_pkg::POS_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic send_pose(input pose_t p, input logic has_want, input pose_t want);
        int    gap;
        pose_t expected;
        gap = (tx_steady || tx_no_gap_left > 0) ? 0 : $urandom_range(0, 10);
        if (tx_no_gap_left > 0)
            tx_no_gap_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rot_00   <= p.rot[0];
        rot_01   <= p.rot[1];
        rot_02   <= p.rot[2];
        rot_10   <= p.rot[3];
        rot_11   <= p.rot[4];
        rot_12   <= p.rot[5];
        rot_20   <= p.rot[6];
        rot_21   <= p.rot[7];
        rot_22   <= p.rot[8];
        pos_x    <= p.pos[0];
        pos_y    <= p.pos[1];
        pos_z    <= p.pos[2];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        if (poses_seen < 2'd2)
            poses_seen++;
        expected = (poses_seen == 2'd2) ? relative_transform(last_pose, p)
                                        : identity_pose();
        if (has_want)
            expected = want;
        last_pose = p;
        expected_log[sent_count] = expected;
        sent_count++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : receiver
        int    stall;
        int    i;
        pose_t got;
        pose_t want;
        string axes;
        axes      = "xyz";
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                stall     = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    rx_steady = !rx_steady;
                stall = rx_steady ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            got.rot[0] = pred_rot_00;
            got.rot[1] = pred_rot_01;
            got.rot[2] = pred_rot_02;
            got.rot[3] = pred_rot_10;
            got.rot[4] = pred_rot_11;
            got.rot[5] = pred_rot_12;
            got.rot[6] = pred_rot_20;
            got.rot[7] = pred_rot_21;
            got.rot[8] = pred_rot_22;
            got.pos[0] = pred_pos_x;
            got.pos[1] = pred_pos_y;
            got.pos[2] = pred_pos_z;
            result_count++;
            if (taken_count >= sent_count)
            begin
                report_mismatch($sformatf("transaction %0d arrived with nothing pending",
                                          result_count));
            end
            else
            begin
                want = expected_log[taken_count];
                taken_count++;
                for (i = 0; i < rpp_pkg::ROT_N; i++)
                begin
                    if (got.rot[i] !== want.rot[i])
                        report_mismatch($sformatf(
                            "transaction %0d pred_rot_%0d%0d: got %0d, expected %0d",
                            result_count, i / 3, i % 3,
                            $signed(got.rot[i]), $signed(want.rot[i])));
                end
                for (i = 0; i < rpp_pkg::POS_N; i++)
                begin
                    if (got.pos[i] !== want.pos[i])
                        report_mismatch($sformatf(
                            "transaction %0d pred_pos_%c: got %0d, expected %0d",
                            result_count, axes[i],
                            $signed(got.pos[i]), $signed(want.pos[i])));
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        pose_t p;
        int    i;
        int    n;
        int    r;
        int    c;
        int    v;
        int    col;
        int    shift;
        int    kind;
        logic  flip;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rot_00         = '0;
        rot_01         = '0;
        rot_02         = '0;
        rot_10         = '0;
        rot_11         = '0;
        rot_12         = '0;
        rot_20         = '0;
        rot_21         = '0;
        rot_22         = '0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        error_count    = 0;
        result_count   = 0;
        sent_count     = 0;
        taken_count    = 0;
        idle_cycles    = 0;
        tx_no_gap_left = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        long_hold      = 1'b0;
        poses_seen     = '0;
        last_pose      = '0;

        // first pose after reset gives the identity, the second sees it
        directed_rows[0]  = make_row(identity_pose(), 1'b1, identity_pose());
        directed_rows[1]  = make_row(pose_from(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                               Q16, 2 * Q16, 3 * Q16), 1'b1,
                                     pose_from(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                               Q16, 2 * Q16, 3 * Q16));
        directed_rows[2]  = make_row(identity_pose(), 1'b1,
                                     pose_from(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                               -Q16, -2 * Q16, -3 * Q16));
        directed_rows[3]  = make_row(pose_from(RMAX, RMAX, RMAX, RMAX, RMAX, RMAX,
                                               RMAX, RMAX, RMAX, PMAX, PMAX, PMAX), 1'b1,
                                     pose_from(RMAX, RMAX, RMAX, RMAX, RMAX, RMAX,
                                               RMAX, RMAX, RMAX, PMAX, PMAX, PMAX));
        // saturation of both rotation and translation
        directed_rows[4]  = make_row(pose_from(RMIN, RMIN, RMIN, RMIN, RMIN, RMIN,
                                               RMIN, RMIN, RMIN, PMIN, PMIN, PMIN), 1'b1,
                                     pose_from(RMIN, RMIN, RMIN, RMIN, RMIN, RMIN,
                                               RMIN, RMIN, RMIN, PMIN, PMIN, PMIN));
        directed_rows[5]  = make_row(pose_from(RMIN, RMIN, RMIN, RMIN, RMIN, RMIN,
                                               RMIN, RMIN, RMIN, PMAX, PMAX, PMAX), 1'b1,
                                     pose_from(RMAX, RMAX, RMAX, RMAX, RMAX, RMAX,
                                               RMAX, RMAX, RMAX, PMIN, PMIN, PMIN));
        directed_rows[6]  = make_row(pose_from(RMIN, RMIN, RMIN, RMIN, RMIN, RMIN,
                                               RMIN, RMIN, RMIN, PMIN, PMIN, PMIN), 1'b1,
                                     pose_from(RMAX, RMAX, RMAX, RMAX, RMAX, RMAX,
                                               RMAX, RMAX, RMAX, PMAX, PMAX, PMAX));
        directed_rows[7]  = make_row(pose_from(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                     pose_from(0, 0, 0, 0, 0, 0, 0, 0, 0,
                                               PMIN, PMIN, PMIN));
        directed_rows[8]  = make_row(identity_pose(), 1'b1,
                                     pose_from(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // rounding ties, both signs
        directed_rows[9]  = make_row(pose_from(1, 0, 0, 0, 1, 0, 0, 0, 1,
                                               1, -1, 32768), 1'b0, '0);
        directed_rows[10] = make_row(pose_from(8192, -8192, -8192, -8192, 8192, -8192,
                                               -8192, -8192, 8192,
                                               8193, -8193, 32768 + 8192), 1'b0, '0);
        directed_rows[11] = make_row(pose_from(0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT,
                                               32'h12345, -32'sh54321, 32'h777777),
                                     1'b0, '0);
        directed_rows[12] = make_row(pose_from(UNIT, 0, 0, 0, -UNIT, 0, 0, 0, -UNIT,
                                               -32'sh100000, 0, 32'h7FFF0000), 1'b0, '0);
        directed_rows[13] = make_row(pose_from(14189, 0, 8192, 0, UNIT, 0,
                                               -8192, 0, 14189,
                                               32'h40000000, -32'sh40000000, 1), 1'b0, '0);
        directed_rows[14] = make_row(pose_from(11585, -11585, 0, 11585, 11585, 0,
                                               0, 0, UNIT, -1, -1, -1), 1'b0, '0);
        directed_rows[15] = make_row(pose_from(RMAX, RMIN, RMAX, RMIN, RMAX, RMIN,
                                               RMAX, RMIN, RMAX, PMAX, PMIN, 0), 1'b0, '0);
        directed_rows[16] = make_row(pose_from(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                               PMIN, PMAX, PMIN), 1'b0, '0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIRECTED_N; i++)
            send_pose(directed_rows[i].stim, directed_rows[i].has_want,
                      directed_rows[i].want);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // receiver holds off while the sender streams back to back
            if (i == HOLD_ITEM)
            begin
                long_hold      = 1'b1;
                tx_no_gap_left = 40;
            end
            if (i == PAUSE_ITEM)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (sent_count != taken_count)
                    @(negedge clk);
            end
            if ($urandom_range(0, 29) == 0)
                tx_steady = !tx_steady;
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                for (n = 0; n < rpp_pkg::ROT_N; n++)
                    p.rot[n] = (rpp_pkg::ROT_W)'($urandom);
                for (n = 0; n < rpp_pkg::POS_N; n++)
                    p.pos[n] = $urandom;
            end
            else if (kind <= 8)
            begin
                // signed permutation with a little noise on every entry
                shift = $urandom_range(0, 2);
                flip  = 1'($urandom_range(0, 1));
                for (r = 0; r < 3; r++)
                begin
                    col = flip ? (shift + 3 - r) % 3 : (r + shift) % 3;
                    for (c = 0; c < 3; c++)
                    begin
                        v = int'($urandom_range(0, 128)) - 64;
                        if (c == col)
                            v += $urandom_range(0, 1) ? -UNIT : UNIT;
                        p.rot[r*3+c] = v[rpp_pkg::ROT_W-1:0];
                    end
                end
                for (n = 0; n < rpp_pkg::POS_N; n++)
                begin
                    if (kind <= 6)
                        p.pos[n] = int'($urandom_range(0, 2097152)) - 1048576;
                    else
                        p.pos[n] = $urandom;
                end
            end
            else
            begin
                for (n = 0; n < rpp_pkg::ROT_N; n++)
                begin
                    case ($urandom_range(0, 4))
                        0:       p.rot[n] = rpp_pkg::ROT_MIN;
                        1:       p.rot[n] = rpp_pkg::ROT_MAX;
                        2:       p.rot[n] = '0;
                        3:       p.rot[n] = '1;
                        default: p.rot[n] = rpp_pkg::ROT_ONE;
                    endcase
                end
                for (n = 0; n < rpp_pkg::POS_N; n++)
                begin
                    case ($urandom_range(0, 4))
                        0:       p.pos[n] = rpp_pkg::POS_MIN;
                        1:       p.pos[n] = rpp_pkg::POS_MAX;
                        2:       p.pos[n] = '0;
                        3:       p.pos[n] = '1;
                        default: p.pos[n] = Q16;
                    endcase
                end
            end
            send_pose(p, 1'b0, p);
        end
        in_valid <= 1'b0;

        while (sent_count != taken_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpp_pkg.sv
rtl/core/relative_pose_predictor_unit.sv
bench/relative_pose_predictor_unit_test.sv
